[hdl/mjpd_pkg.sv]
package mjpd_pkg;

   localparam int LINE_KEEP_DEFAULT   = 127;
   localparam int LENGTH_BITS_DEFAULT = 24;

   localparam int BYTE_BITS         = 8;
   localparam int QUEUE_BITS        = 16;
   localparam int THRESHOLD_BITS    = 16;
   localparam int FRAME_LENGTH_BITS = 24;
   localparam int STATUS_BITS       = 2;
   localparam int CSR_INDEX_BITS    = 4;
   localparam int CSR_DATA_BITS     = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DROP_THRESHOLD  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FRAME_BYTES = 4'd1;

   localparam logic [THRESHOLD_BITS-1:0]    DROP_THRESHOLD_RESET  = 16'd2048;
   localparam logic [THRESHOLD_BITS-1:0]    MIN_THRESHOLD         = 16'd2048;
   localparam logic [FRAME_LENGTH_BITS-1:0] MAX_FRAME_BYTES_RESET = 24'd65536;

   localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0D;

   localparam logic [STATUS_BITS-1:0] STATUS_PAYLOAD      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DROP_BACKLOG = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_DROP_BIG     = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER       = 2'd0,
      PH_KEEP         = 2'd1,
      PH_SKIP_BACKLOG = 2'd2,
      PH_SKIP_BIG     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      SM_NONE = 2'd0,
      SM_FF   = 2'd1,
      SM_SOI  = 2'd2,
      SM_BAD  = 2'd3
   } marker_type;

   // Summary of the header line in progress, valid when the current request is a line feed.
   typedef struct packed {
      logic short_line;
      logic set_length;
   } hdr_line_type;

endpackage

[hdl/mjpd_hdr_parser.sv]
module mjpd_hdr_parser #(
   parameter int LINE_KEEP   = mjpd_pkg::LINE_KEEP_DEFAULT,
   parameter int LENGTH_BITS = mjpd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [mjpd_pkg::BYTE_BITS-1:0]  char_in,
   output mjpd_pkg::hdr_line_type          line_info,
   output logic [LENGTH_BITS-1:0]          line_length
);

   localparam int LCW = $clog2(LINE_KEEP + 1);

   localparam logic [4:0] MS_PREFIX_DONE = 5'd15;
   localparam logic [4:0] MS_SIGN        = 5'd16;
   localparam logic [4:0] MS_DIGITS      = 5'd17;
   localparam logic [4:0] MS_DONE        = 5'd18;
   localparam logic [4:0] MS_FAIL        = 5'd19;

   logic [LCW-1:0]         line_count_ff, line_count_in;
   logic [4:0]             match_ff, match_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [LENGTH_BITS+3:0] product;
   logic [LENGTH_BITS-1:0] acc_digit;
   logic                   is_digit;
   logic                   is_blank;
   logic [7:0]             lower;

   function automatic logic [7:0] key_char(input logic [4:0] idx);
      logic [7:0] ch;
      unique case (idx)
         5'd0:    ch = "c";
         5'd1:    ch = "o";
         5'd2:    ch = "n";
         5'd3:    ch = "t";
         5'd4:    ch = "e";
         5'd5:    ch = "n";
         5'd6:    ch = "t";
         5'd7:    ch = "-";
         5'd8:    ch = "l";
         5'd9:    ch = "e";
         5'd10:   ch = "n";
         5'd11:   ch = "g";
         5'd12:   ch = "t";
         5'd13:   ch = "h";
         5'd14:   ch = ":";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
   assign is_blank = (char_in == 8'h20) || (char_in == 8'h09) || (char_in == 8'h0B) ||
                     (char_in == 8'h0C);
   assign lower    = ((char_in >= 8'h41) && (char_in <= 8'h5A)) ? char_in + 8'h20 : char_in;

   assign product   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                      (LENGTH_BITS + 4)'(char_in - 8'h30);
   assign acc_digit = (|product[LENGTH_BITS+3:LENGTH_BITS]) ? '1 : product[LENGTH_BITS-1:0];

   assign line_info.short_line = (line_count_ff <= LCW'(1));
   assign line_info.set_length = (line_count_ff > LCW'(14)) && (match_ff >= MS_PREFIX_DONE) &&
                                 (match_ff <= MS_DONE);
   assign line_length = neg_ff ? '0 : acc_ff;

   always_comb begin
      line_count_in = line_count_ff;
      match_in      = match_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      if (step) begin
         if (char_in == mjpd_pkg::CHAR_LF) begin
            line_count_in = '0;
            match_in      = '0;
            acc_in        = '0;
            neg_in        = 1'b0;
         end else if (char_in != mjpd_pkg::CHAR_CR && line_count_ff < LCW'(LINE_KEEP)) begin
            line_count_in = line_count_ff + LCW'(1);
            priority if (match_ff >= MS_DONE) begin
               match_in = match_ff;
            end else if (char_in == 8'h00) begin
               match_in = (match_ff < MS_PREFIX_DONE) ? MS_FAIL : MS_DONE;
            end else if (match_ff == 5'd0 && is_blank) begin
               match_in = match_ff;
            end else if (match_ff < MS_PREFIX_DONE) begin
               match_in = (lower == key_char(match_ff)) ? match_ff + 5'd1 : MS_FAIL;
            end else if (match_ff == MS_PREFIX_DONE) begin
               priority if (is_blank) begin
                  match_in = match_ff;
               end else if (char_in == 8'h2B) begin
                  match_in = MS_SIGN;
               end else if (char_in == 8'h2D) begin
                  neg_in   = 1'b1;
                  match_in = MS_SIGN;
               end else if (is_digit) begin
                  acc_in   = acc_digit;
                  match_in = MS_DIGITS;
               end else begin
                  match_in = MS_DONE;
               end
            end else if (is_digit) begin
               acc_in   = acc_digit;
               match_in = MS_DIGITS;
            end else begin
               match_in = MS_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
         match_ff      <= '0;
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
      end else begin
         line_count_ff <= line_count_in;
         match_ff      <= match_in;
         acc_ff        <= acc_in;
         neg_ff        <= neg_in;
      end
   end

endmodule

[hdl/mjpd_frame_ctrl.sv]
module mjpd_frame_ctrl #(
   parameter int LENGTH_BITS = mjpd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic [mjpd_pkg::BYTE_BITS-1:0]          char_in,
   input  logic [mjpd_pkg::QUEUE_BITS-1:0]         queued_in,
   input  mjpd_pkg::hdr_line_type                  line_info,
   input  logic [LENGTH_BITS-1:0]                  line_length,
   input  logic [mjpd_pkg::THRESHOLD_BITS-1:0]     drop_threshold,
   input  logic [mjpd_pkg::FRAME_LENGTH_BITS-1:0]  max_frame_bytes,
   output logic                                    in_header,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [mjpd_pkg::BYTE_BITS-1:0]          rsp_out_byte,
   output logic                                    rsp_first_of_frame,
   output logic                                    rsp_last_of_frame,
   output logic [mjpd_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic                                    rsp_soi_ok,
   output logic [mjpd_pkg::FRAME_LENGTH_BITS-1:0]  rsp_frame_length
);

   localparam int FLB = mjpd_pkg::FRAME_LENGTH_BITS;
   localparam int CW  = (LENGTH_BITS > FLB) ? LENGTH_BITS : FLB;

   mjpd_pkg::phase_type    phase_ff, phase_in;
   mjpd_pkg::marker_type   marker_ff, marker_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [LENGTH_BITS-1:0] len_next;
   logic [mjpd_pkg::THRESHOLD_BITS-1:0] thr;
   logic [FLB-1:0]         len_sat;
   logic                   last;
   logic                   produce;

   logic                              out_valid_ff, out_valid_in;
   logic [mjpd_pkg::BYTE_BITS-1:0]    out_byte_ff, out_byte_in;
   logic                              out_first_ff, out_first_in;
   logic                              out_last_ff, out_last_in;
   logic [mjpd_pkg::STATUS_BITS-1:0]  out_status_ff, out_status_in;
   logic                              out_soi_ff, out_soi_in;
   logic [FLB-1:0]                    out_length_ff, out_length_in;

   assign in_header = (phase_ff == mjpd_pkg::PH_HEADER);
   assign thr       = (drop_threshold < mjpd_pkg::MIN_THRESHOLD) ? mjpd_pkg::MIN_THRESHOLD :
                      drop_threshold;
   assign len_next  = line_info.set_length ? line_length : length_ff;
   assign len_sat   = (CW'(length_ff) > CW'({FLB{1'b1}})) ? {FLB{1'b1}} : FLB'(length_ff);
   assign last      = (left_ff <= LENGTH_BITS'(1));

   always_comb begin
      phase_in      = phase_ff;
      marker_in     = marker_ff;
      length_in     = length_ff;
      left_in       = left_ff;
      produce       = 1'b0;
      out_byte_in   = out_byte_ff;
      out_first_in  = out_first_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_soi_in    = out_soi_ff;
      out_length_in = out_length_ff;
      if (advance) begin
         unique case (phase_ff)
            mjpd_pkg::PH_HEADER: begin
               if (char_in == mjpd_pkg::CHAR_LF) begin
                  length_in = len_next;
                  if (line_info.short_line && len_next != '0) begin
                     left_in   = len_next;
                     marker_in = mjpd_pkg::SM_NONE;
                     priority if (CW'(len_next) > CW'(max_frame_bytes)) begin
                        phase_in = mjpd_pkg::PH_SKIP_BIG;
                     end else if (queued_in > thr) begin
                        phase_in = mjpd_pkg::PH_SKIP_BACKLOG;
                     end else begin
                        phase_in = mjpd_pkg::PH_KEEP;
                     end
                  end
               end
            end
            mjpd_pkg::PH_KEEP: begin
               unique case (marker_ff)
                  mjpd_pkg::SM_NONE: marker_in = (char_in == 8'hFF) ? mjpd_pkg::SM_FF :
                                                 mjpd_pkg::SM_BAD;
                  mjpd_pkg::SM_FF:   marker_in = (char_in == 8'hD8) ? mjpd_pkg::SM_SOI :
                                                 mjpd_pkg::SM_BAD;
                  default:           marker_in = marker_ff;
               endcase
               produce       = 1'b1;
               out_byte_in   = char_in;
               out_first_in  = (marker_ff == mjpd_pkg::SM_NONE);
               out_last_in   = last;
               out_status_in = mjpd_pkg::STATUS_PAYLOAD;
               out_soi_in    = last && (marker_in == mjpd_pkg::SM_SOI);
               out_length_in = len_sat;
            end
            default: begin
               if (last) begin
                  produce       = 1'b1;
                  out_byte_in   = '0;
                  out_first_in  = 1'b0;
                  out_last_in   = 1'b1;
                  out_status_in = (phase_ff == mjpd_pkg::PH_SKIP_BIG) ?
                                  mjpd_pkg::STATUS_DROP_BIG : mjpd_pkg::STATUS_DROP_BACKLOG;
                  out_soi_in    = 1'b0;
                  out_length_in = len_sat;
               end
            end
         endcase
         if (phase_ff != mjpd_pkg::PH_HEADER) begin
            if (last) begin
               phase_in  = mjpd_pkg::PH_HEADER;
               length_in = '0;
               left_in   = '0;
               marker_in = mjpd_pkg::SM_NONE;
            end else begin
               left_in = left_ff - LENGTH_BITS'(1);
            end
         end
      end
      out_valid_in = produce ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mjpd_pkg::PH_HEADER;
         marker_ff    <= mjpd_pkg::SM_NONE;
         length_ff    <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         marker_ff    <= marker_in;
         length_ff    <= length_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_first_ff  <= out_first_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_soi_ff    <= out_soi_in;
      out_length_ff <= out_length_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_first_of_frame = out_first_ff;
   assign rsp_last_of_frame  = out_last_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_soi_ok         = out_soi_ff;
   assign rsp_frame_length   = out_length_ff;

endmodule

[hdl/mjpeg_part_deframer.sv]
// Splits a multipart MJPEG byte stream into frames using the Content-Length header lines.
// The request channel (req_valid, req_stall) carries one stream byte per request together
// with the source backlog count; the result channel (rsp_valid, rsp_stall) carries at most
// one result per request: a frame payload byte, or a single drop report on the last byte
// of a skipped frame. Header bytes give no result.
// A request is registered in the input register on acceptance, processed once the output
// register can take its result, and its result is held in the output register until the
// receiver takes it. The block takes one request every cycle while results are being taken;
// the backlog limit and frame size limit are written through the csr_ port, which is always
// ready; the user must write them only while the block is idle, not enforced by the block.
// When the receiver stalls, the pending result is held, the request in the input register
// waits, and req_stall is raised until the output register can take a new result.
// Reset (synchronous, active high) returns to header parsing with no frame length,
// empties both registers and sets the limits to 2048 bytes of backlog and 65536-byte
// frames.
module mjpeg_part_deframer #(
   parameter int LINE_KEEP   = mjpd_pkg::LINE_KEEP_DEFAULT,
   parameter int LENGTH_BITS = mjpd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [mjpd_pkg::BYTE_BITS-1:0]          req_in_byte,
   input  logic [mjpd_pkg::QUEUE_BITS-1:0]         req_queued_bytes,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [mjpd_pkg::BYTE_BITS-1:0]          rsp_out_byte,
   output logic                                    rsp_first_of_frame,
   output logic                                    rsp_last_of_frame,
   output logic [mjpd_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic                                    rsp_soi_ok,
   output logic [mjpd_pkg::FRAME_LENGTH_BITS-1:0]  rsp_frame_length,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mjpd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mjpd_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   logic                                   in_valid_ff, in_valid_in;
   logic [mjpd_pkg::BYTE_BITS-1:0]         in_byte_ff;
   logic [mjpd_pkg::QUEUE_BITS-1:0]        in_queued_ff;
   logic [mjpd_pkg::THRESHOLD_BITS-1:0]    drop_threshold_ff;
   logic [mjpd_pkg::FRAME_LENGTH_BITS-1:0] max_frame_bytes_ff;
   logic                                   advance;
   logic                                   accept;
   logic                                   in_header;
   mjpd_pkg::hdr_line_type                 line_info;
   logic [LENGTH_BITS-1:0]                 line_length;

   assign advance     = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff   <= req_in_byte;
         in_queued_ff <= req_queued_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_threshold_ff  <= mjpd_pkg::DROP_THRESHOLD_RESET;
         max_frame_bytes_ff <= mjpd_pkg::MAX_FRAME_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == mjpd_pkg::CSR_DROP_THRESHOLD) begin
            drop_threshold_ff <= csr_wdata[mjpd_pkg::THRESHOLD_BITS-1:0];
         end
         if (csr_index == mjpd_pkg::CSR_MAX_FRAME_BYTES) begin
            max_frame_bytes_ff <= csr_wdata[mjpd_pkg::FRAME_LENGTH_BITS-1:0];
         end
      end
   end

   mjpd_hdr_parser #(
      .LINE_KEEP   (LINE_KEEP),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_hdr_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance && in_header),
      .char_in     (in_byte_ff),
      .line_info   (line_info),
      .line_length (line_length)
   );

   mjpd_frame_ctrl #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_frame_ctrl (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .char_in            (in_byte_ff),
      .queued_in          (in_queued_ff),
      .line_info          (line_info),
      .line_length        (line_length),
      .drop_threshold     (drop_threshold_ff),
      .max_frame_bytes    (max_frame_bytes_ff),
      .in_header          (in_header),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_first_of_frame (rsp_first_of_frame),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_status         (rsp_status),
      .rsp_soi_ok         (rsp_soi_ok),
      .rsp_frame_length   (rsp_frame_length)
   );

endmodule
